[design/pds_pkg.sv]
// Shared types, constants and arithmetic helpers for the 2x2 pyramid downsampler.
// Used by pds_raster_ctrl, pds_line_store and pyramid_downsample_2x2; no dependencies.
`default_nettype none

package pds_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_MAX_HEIGHT = 4096;
   localparam int RESET_DIM          = 4096;

   localparam int SAMPLE_W   = 16;
   localparam int PIXEL_W    = 4 * SAMPLE_W;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_INDEX_W = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 8'd0,
      REG_IMAGE_HEIGHT = 8'd1
   } csr_reg_type;

   // red in the lowest bits, key in the highest
   typedef struct packed {
      logic [SAMPLE_W-1:0] key;
      logic [SAMPLE_W-1:0] blue;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] red;
   } pixel_type;

   // one line store entry: an even and an odd column of the same even row
   typedef struct packed {
      pixel_type odd;
      pixel_type even;
   } pixel_pair_type;

   // position of the next pixel as seen by the datapath
   typedef struct packed {
      logic row_odd;
      logic col_odd;
      logic at_last;
   } pos_type;

   function automatic logic [SAMPLE_W-1:0] mean4(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b,
                                                 input logic [SAMPLE_W-1:0] c,
                                                 input logic [SAMPLE_W-1:0] d);
      logic [SAMPLE_W+1:0] sum;
      sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      return sum[SAMPLE_W+1:2];
   endfunction

   function automatic logic [SAMPLE_W-1:0] max4(input logic [SAMPLE_W-1:0] a,
                                                input logic [SAMPLE_W-1:0] b,
                                                input logic [SAMPLE_W-1:0] c,
                                                input logic [SAMPLE_W-1:0] d);
      logic [SAMPLE_W-1:0] m_ab;
      logic [SAMPLE_W-1:0] m_cd;
      m_ab = (a > b) ? a : b;
      m_cd = (c > d) ? c : d;
      return (m_ab > m_cd) ? m_ab : m_cd;
   endfunction

   function automatic pixel_type combine(input pixel_type a, input pixel_type b,
                                         input pixel_type c, input pixel_type d);
      pixel_type p;
      p.red   = mean4(a.red, b.red, c.red, d.red);
      p.green = mean4(a.green, b.green, c.green, d.green);
      p.blue  = mean4(a.blue, b.blue, c.blue, d.blue);
      p.key   = max4(a.key, b.key, c.key, d.key);
      return p;
   endfunction

endpackage

`default_nettype wire

[design/pyramid_downsample_2x2.sv]
// Top level of the 2x2 box pyramid downsampler: handshakes, pixel hold and output register.
// Depends on pds_pkg, pds_raster_ctrl and pds_line_store.
//
// Usage:
//   req_* carries one input pixel per transfer in raster order; rsp_* carries one
//   half-size output pixel per 2x2 block, with rsp_tlast on the last one of a frame.
//   csr_* writes image_width (index 0) or image_height (index 1); a write restarts
//   the frame at column 0, row 0. Write only while the block is idle.
// Throughput: one input pixel per cycle while the output does not stall. Pixels of
//   even rows go into the line store as column pairs; at an even column of an odd row
//   the pair is read, and the odd column pixel that follows completes the block from
//   the read word, the held left pixel and itself.
// Latency: the output pixel is valid in the cycle after the transfer of the odd
//   column, odd row pixel that completes its block.
// Stall: the output register holds while rsp_tready is low; req_tready then drops
//   so no pixel is taken until the result has been transferred.
// Reset: counters and output valid clear, width and height return to 4096 (clamped
//   to the maximum). The line store has no clearing pass: an odd row only reads
//   pairs written by the even row before it.
// Odd width or height: the last column or row is consumed and produces nothing.
`default_nettype none

module pyramid_downsample_2x2
   import pds_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input pixels
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [PIXEL_W-1:0]     req_tdata,  // red_in, green_in, blue_in, key_in
   // output pixels
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [PIXEL_W-1:0]     rsp_tdata,  // red_out, green_out, blue_out, key_out
   output      logic                   rsp_tlast,  // frame_last
   // configuration writes
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int PAIR_W     = $clog2(PAIR_DEPTH);

   logic           accept;
   logic           csr_write;
   logic [COL_W-1:0] col;
   pos_type        pos;
   pixel_type      cur;
   pixel_type      hold_ff;
   pixel_pair_type store_wdata;
   pixel_pair_type store_rdata;
   logic           store_we;
   logic           store_re;
   logic [PAIR_W-1:0] store_addr;
   logic           rsp_load;
   logic           rsp_valid_ff, rsp_valid_in;
   pixel_type      rsp_data_ff;
   logic           rsp_last_ff;

   // configuration is always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // take a new pixel whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cur        = pixel_type'(req_tdata);

   pds_raster_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_raster_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .col       (col),
      .pos       (pos)
   );

   // hold the even column pixel of every row: it pairs with the next odd column
   always_ff @(posedge clock) begin
      if (accept && !pos.col_odd) begin
         hold_ff <= cur;
      end
   end

   // even row: write the completed pair at the odd column
   // odd row: fetch the pair at the even column, ready for the odd column next
   assign store_we         = accept && !pos.row_odd && pos.col_odd;
   assign store_re         = accept && pos.row_odd && !pos.col_odd;
   assign store_addr       = PAIR_W'(col >> 1);
   assign store_wdata.even = hold_ff;
   assign store_wdata.odd  = cur;

   pds_line_store #(
      .DEPTH  (PAIR_DEPTH),
      .ADDR_W (PAIR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_we),
      .rd_en   (store_re),
      .addr    (store_addr),
      .wr_data (store_wdata),
      .rd_data (store_rdata)
   );

   // odd row, odd column completes a block
   assign rsp_load = accept && pos.row_odd && pos.col_odd;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= combine(store_rdata.even, store_rdata.odd, hold_ff, cur);
         rsp_last_ff <= pos.at_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a result only appears after an input transfer
   a_rsp_from_accept : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("output valid rose without an input transfer");

   // a register write restarts the frame at an even row, even column
   a_cfg_restarts : assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT))
      |=> (!pos.row_odd && !pos.col_odd))
      else $error("register write did not restart the frame");

   // never take a pixel while a result is stuck in the output register
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output stalled");

endmodule

`default_nettype wire

[design/pds_line_store.sv]
// Line store of column pairs for the 2x2 pyramid downsampler.
// Single-port synchronous memory, registered read; depends on pds_pkg.
`default_nettype none

module pds_line_store
   import pds_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_WIDTH / 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic           rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire pixel_pair_type wr_data,
   output      pixel_pair_type rd_data
);

   pixel_pair_type mem [DEPTH];
   pixel_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/pds_raster_ctrl.sv]
// Raster position counters and frame size registers for the 2x2 pyramid downsampler.
// Depends on pds_pkg.
`default_nettype none

module pds_raster_ctrl
   import pds_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   advance,
   output      logic [COL_W-1:0]       col,
   output      pos_type                pos
);

   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
   localparam int RESET_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
   localparam int RESET_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

   logic [WDIM_W-1:0] width_ff, width_in;
   logic [HDIM_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              cfg_hit;
   logic              col_end, row_end;
   logic [WDIM_W-1:0] last_col;
   logic [HDIM_W-1:0] last_row;

   // decode writes; clamp into the supported range
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      cfg_hit   = 1'b0;
      if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_IMAGE_WIDTH: begin
               cfg_hit = 1'b1;
               if (csr_wdata < CSR_DATA_W'(2)) begin
                  width_in = WDIM_W'(2);
               end else if (32'(csr_wdata) > MAX_WIDTH) begin
                  width_in = WDIM_W'(MAX_WIDTH);
               end else begin
                  width_in = WDIM_W'(csr_wdata);
               end
            end
            REG_IMAGE_HEIGHT: begin
               cfg_hit = 1'b1;
               if (csr_wdata < CSR_DATA_W'(2)) begin
                  height_in = HDIM_W'(2);
               end else if (32'(csr_wdata) > MAX_HEIGHT) begin
                  height_in = HDIM_W'(MAX_HEIGHT);
               end else begin
                  height_in = HDIM_W'(csr_wdata);
               end
            end
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   assign col_end = (WDIM_W'(col_ff) == width_ff - WDIM_W'(1));
   assign row_end = (HDIM_W'(row_ff) == height_ff - HDIM_W'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WDIM_W'(RESET_W);
         height_ff <= HDIM_W'(RESET_H);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // last emitted block ends at the last even-aligned column and row
   assign last_col = (width_ff & ~WDIM_W'(1)) - WDIM_W'(1);
   assign last_row = (height_ff & ~HDIM_W'(1)) - HDIM_W'(1);

   assign col         = col_ff;
   assign pos.row_odd = row_ff[0];
   assign pos.col_odd = col_ff[0];
   assign pos.at_last = (WDIM_W'(col_ff) == last_col) && (HDIM_W'(row_ff) == last_row);

endmodule

`default_nettype wire

[tb/tb_pyramid_downsample_2x2.sv]
// Self-checking testbench for the 2x2 pyramid downsampler.
// Needs pds_pkg and pyramid_downsample_2x2; a predictor class tracks the line store and checks
// every output pixel.
`timescale 1ns / 100ps

module tb_pyramid_downsample_2x2;
   import pds_pkg::*;

   localparam int          MAX_DIM      = 4096;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          LONG_HOLD    = 400;
   localparam int          RANDOM_ITEMS = 1500;
   localparam longint      CYCLE_LIMIT  = 1000000;
   // index that maps to no register; its bits complement those of the height index
   localparam logic [CSR_INDEX_W-1:0] REG_NONE = 8'hFE;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } out_pixel_type;

   // Tracks the line store, the left pixel and the raster position, and keeps the output
   // pixels that are due, oldest first.
   class box_filter_model;
      pixel_type       line_buf [MAX_DIM];
      pixel_type       left_pix;
      int unsigned     col, row;
      logic [12:0]     width_reg, height_reg;
      out_pixel_type   due_pixels[$];
      int              errors;

      function new();
         foreach (line_buf[i]) line_buf[i] = '0;
         left_pix   = '0;
         col        = 0;
         row        = 0;
         width_reg  = 13'd4096;
         height_reg = 13'd4096;
         errors     = 0;
      endfunction

      function int unsigned clamp_dim(logic [12:0] v);
         if (v < 2) return 2;
         if (v > MAX_DIM) return MAX_DIM;
         return 32'(v);
      endfunction

      function int unsigned frame_pixels();
         return clamp_dim(width_reg) * clamp_dim(height_reg);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == REG_IMAGE_WIDTH) width_reg = val;
         else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
         else return;
         col = 0;
         row = 0;
      endfunction

      function logic [15:0] box_mean(logic [15:0] a, logic [15:0] b,
                                     logic [15:0] c, logic [15:0] d);
         int unsigned s;
         s = int'(a) + int'(b) + int'(c) + int'(d);
         return s[17:2];
      endfunction

      function logic [15:0] key_max(logic [15:0] a, logic [15:0] b,
                                    logic [15:0] c, logic [15:0] d);
         logic [15:0] m;
         m = a;
         if (b > m) m = b;
         if (c > m) m = c;
         if (d > m) m = d;
         return m;
      endfunction

      function void take_pixel(pixel_type cur);
         int unsigned   w, h;
         pixel_type     a, b;
         out_pixel_type e;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         if (row[0] == 1'b0) begin
            line_buf[col] = cur;
         end else if (col[0] == 1'b0) begin
            left_pix = cur;
         end else begin
            a = line_buf[col-1];
            b = line_buf[col];
            e.pix.red   = box_mean(a.red, b.red, left_pix.red, cur.red);
            e.pix.green = box_mean(a.green, b.green, left_pix.green, cur.green);
            e.pix.blue  = box_mean(a.blue, b.blue, left_pix.blue, cur.blue);
            e.pix.key   = key_max(a.key, b.key, left_pix.key, cur.key);
            e.last      = (col == (w & ~1) - 1) && (row == (h & ~1) - 1);
            due_pixels  = {due_pixels, e};
         end
         col++;
         if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
         end
      endfunction

      function void mismatch(string what, longint unsigned exp, longint unsigned got);
         errors++;
         if (errors <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, exp, got);
      endfunction

      function void check_output(logic [PIXEL_W-1:0] data, logic last);
         out_pixel_type e;
         pixel_type     got;
         got = pixel_type'(data);
         if (due_pixels.size() == 0) begin
            mismatch("unexpected output pixel", 64'd0, 64'(data));
            return;
         end
         e = due_pixels.pop_front();
         if (got.red   !== e.pix.red)
            mismatch("red", 64'(e.pix.red), 64'(got.red));
         if (got.green !== e.pix.green)
            mismatch("green", 64'(e.pix.green), 64'(got.green));
         if (got.blue  !== e.pix.blue)
            mismatch("blue", 64'(e.pix.blue), 64'(got.blue));
         if (got.key   !== e.pix.key)
            mismatch("key", 64'(e.pix.key), 64'(got.key));
         if (last      !== e.last)
            mismatch("frame end", 64'(e.last), 64'(last));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata;   // red_in, green_in, blue_in, key_in
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [PIXEL_W-1:0]     rsp_tdata;   // red_out, green_out, blue_out, key_out
   logic                   rsp_tlast;   // frame_last
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   box_filter_model model;
   int              burst_left;
   int              long_hold_asks;
   longint          cycles;

   pyramid_downsample_2x2 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: abandon the run if the block stops moving.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_pyramid_downsample_2x2 failed");
         $finish;
      end
   end

   // Observe both streams at the rising edge: check the output first, then note the input.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) model.check_output(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) model.take_pixel(pixel_type'(req_tdata));
      end
   end

   // Receiver: stretches of steady readiness, coin-flip readiness and short stall runs, plus
   // one long hold-off whenever the stimulus asks for it, so the block backs up into its input.
   initial begin : rsp_side
      int mode;
      int run;
      int holds_done;
      rsp_tready = 1'b0;
      holds_done = 0;
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(10, 60);
         repeat (run) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_tready = 1'b1;
               end
               1: begin
                  rsp_tready = 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready = ($urandom_range(0, 4) != 0);
               end
               default: begin
                  rsp_tready = ($urandom_range(0, 4) == 0);
               end
            endcase
         end
         if (long_hold_asks != holds_done) begin
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holds_done = long_hold_asks;
         end
      end
   end

   // Offer one pixel; called at a falling edge and returns at a falling edge. Gaps fall only
   // between bursts, so valid stays high from one pixel to the next inside a burst.
   task automatic send_pixel(input pixel_type p);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 4))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(1, 2);
            3:       gap = $urandom_range(3, 6);
            default: gap = $urandom_range(7, 12);
         endcase
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tdata  = p;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
   endtask

   // Wait for every due pixel, then for the pipeline to settle; returns at a falling edge.
   task automatic wait_idle();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (model.due_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      model.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Unless style is 0, samples lean towards the extremes to catch sum overflow and key ordering.
   function automatic logic [15:0] rand_sample(int style);
      if (style == 0) return 16'($urandom);
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'hFFF0 | 16'($urandom_range(0, 15));
         3:       return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pixel_type rand_pixel(int style);
      pixel_type p;
      p.red   = rand_sample(style);
      p.green = rand_sample(style);
      p.blue  = rand_sample(style);
      p.key   = rand_sample(style);
      return p;
   endfunction

   task automatic send_random(input int count, input int style);
      repeat (count) send_pixel(rand_pixel(style));
   endtask

   initial begin : stimulus
      pixel_type   p;
      int          random_sent;
      int          frames;
      int          count;
      logic [12:0] w, h;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      burst_left  = 0;
      cycles      = 0;
      long_hold_asks = 0;
      random_sent = 0;
      model       = new();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Default size after reset: a few pixels of the first even row, nothing comes out.
      send_random(5, 1);
      wait_idle();

      // Out-of-range sizes clamp to the 2x2 minimum.
      write_csr(REG_IMAGE_WIDTH, 13'd0);
      write_csr(REG_IMAGE_HEIGHT, 13'd1);

      // All-ones block: the sum needs two extra bits. Split it around a write to no register,
      // which must leave the raster position alone.
      p = '1;
      send_pixel(p);
      send_pixel(p);
      wait_idle();
      write_csr(REG_NONE, 13'h1FFF);
      send_pixel(p);
      send_pixel(p);

      // All-zero block.
      p = '0;
      repeat (4) send_pixel(p);

      // Odd width and height: last column and last row are consumed without output.
      wait_idle();
      write_csr(REG_IMAGE_WIDTH, 13'd3);
      write_csr(REG_IMAGE_HEIGHT, 13'd3);
      for (int i = 0; i < 9; i++) begin
         p.red   = 16'(16'h1000 * i + 16'h0003);
         p.green = 16'(16'hFFFF - 16'h0101 * i);
         p.blue  = (i == 4) ? 16'hFFFF : 16'h0001;
         p.key   = (i == 1) ? 16'hFFFE : 16'(16'h0100 * i);
         send_pixel(p);
      end

      // Random frames of small size, some cut short by the next register write.
      long_hold_asks++;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w = 13'($urandom_range(0, 1));
            1:       w = 13'($urandom_range(13, 40));
            default: w = 13'($urandom_range(2, 12));
         endcase
         h = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 1))
                                         : 13'($urandom_range(2, 8));
         wait_idle();
         write_csr(REG_IMAGE_WIDTH, w);
         if (random_sent == 0 || $urandom_range(0, 3) != 0)
            write_csr(REG_IMAGE_HEIGHT, h);
         frames = $urandom_range(1, 3);
         count  = frames * model.frame_pixels();
         if ($urandom_range(0, 5) == 0)
            count += $urandom_range(1, model.frame_pixels() - 1);
         send_random(count, $urandom_range(0, 1));
         random_sent += count;
      end

      // Start of the widest row with the lowest height: even row only, nothing comes out.
      wait_idle();
      write_csr(REG_IMAGE_WIDTH, 13'd4096);
      write_csr(REG_IMAGE_HEIGHT, 13'd1);
      long_hold_asks++;
      send_random(64, 1);

      // Narrowest row with a height beyond the maximum, clamped to the tallest frame.
      wait_idle();
      write_csr(REG_IMAGE_WIDTH, 13'd2);
      write_csr(REG_IMAGE_HEIGHT, 13'h1FFF);
      send_random(64, 0);

      // Drain and settle before the verdict.
      wait_idle();
      if (model.errors == 0 && model.due_pixels.size() == 0) begin
         $display("tb_pyramid_downsample_2x2 passed");
      end else begin
         $display("tb_pyramid_downsample_2x2 failed");
      end
      $finish;
   end

endmodule
